// ----- hw/rtl/stcp_pkg.sv -----
// Shared types, constants and helper functions of the serial table command parser.
package stcp_pkg;

  localparam int unsigned TableRowsDef = 16;
  localparam int unsigned TableColsDef = 16;

  localparam logic [31:0] AckEnd    = 32'h8000_0002;
  localparam logic [15:0] CheckInit = 16'hFFFF;

  localparam logic [15:0] TimeoutRst  = 16'd100;
  localparam logic [31:0] RatioMinRst = 32'd1092616192;
  localparam logic [31:0] RatioMaxRst = 32'd1101004800;

  typedef enum logic [7:0] {
    CMD_PING  = 8'd0,
    CMD_SET   = 8'd1,
    CMD_CLEAR = 8'd2,
    CMD_WRITE = 8'd4,
    CMD_READ  = 8'd5
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_ACK     = 2'd0,
    OUT_CHECK   = 2'd1,
    OUT_CELL    = 2'd2,
    OUT_TIMEOUT = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_MIN     = 2'd1,
    CFG_MAX     = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    PH_IDLE,
    PH_PAYLOAD
  } phase_e;

  // Payload length in bytes after the id; zero means the id is dropped.
  function automatic logic [3:0] payload_len(logic [7:0] id);
    logic [3:0] len;
    case (id)
      CMD_PING, CMD_SET, CMD_CLEAR: len = 4'd2;
      CMD_WRITE:                    len = 4'd9;
      CMD_READ:                     len = 4'd5;
      default:                      len = 4'd0;
    endcase
    return len;
  endfunction

  // IEEE single a < b; false if either is NaN, +0 and -0 compare equal.
  function automatic logic f32_lt(logic [31:0] a, logic [31:0] b);
    logic a_nan, b_nan, both_zero, lt;
    a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a[31] != b[31]) begin
      lt = a[31];
    end else if (a[31]) begin
      lt = a[30:0] > b[30:0];
    end else begin
      lt = a[30:0] < b[30:0];
    end
    return lt && !a_nan && !b_nan && !both_zero;
  endfunction

endpackage

// ----- hw/rtl/stcp_clamp.sv -----
// Float clamp of a table value against the configured min and max bit patterns.
module stcp_clamp (
  input  logic [31:0] value_i,
  input  logic [31:0] min_i,
  input  logic [31:0] max_i,
  output logic [31:0] result_o
);

  always_comb begin
    if (stcp_pkg::f32_lt(value_i, min_i)) begin
      result_o = min_i;
    end else if (stcp_pkg::f32_lt(max_i, value_i)) begin
      result_o = max_i;
    end else begin
      result_o = value_i;
    end
  end

endmodule

// ----- hw/rtl/serial_table_command_parser.sv -----
// Top level of the serial table command parser: parser, ratio table memory, reply sequencer.
// Each input transaction (serial byte or timer tick) is taken in one handshake. A command that
// completes loads a reply of 1, 5, 8 or 12 results, sent one per cycle from a shift buffer
// while the receiver is ready; meanwhile bytes and ticks that cause no result are still
// accepted, while one that would finish a command or time out waits until the buffer is
// empty. The ratio table lives in a synchronous RAM of TABLE_ROWS*TABLE_COLS words; a read
// of a cell is issued when its column byte arrives. After reset a clearing pass zeroes the
// table, one word per cycle, during which no input is accepted (configuration writes are).
module serial_table_command_parser #(
  parameter int unsigned TABLE_ROWS = stcp_pkg::TableRowsDef,
  parameter int unsigned TABLE_COLS = stcp_pkg::TableColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] tx_byte, [9:8] outcome, [10] sending_flag
  output logic        m_axis_tuser_o,   // [0] byte_valid
  output logic        m_axis_tlast_o
);

  localparam int unsigned Depth = TABLE_ROWS * TABLE_COLS;
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;

  // configuration
  logic [15:0] timeout_q;
  logic [31:0] min_q, max_q;

  // parser state
  stcp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  id_q, id_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  row_q, row_d, col_q, col_d, cklo_q, cklo_d;
  logic [31:0] val_q, val_d;
  logic [15:0] exp_q, exp_d, wait_q, wait_d;
  logic        send_q, send_d;

  // clearing pass
  logic          clearing_q;
  logic [Aw-1:0] clr_q;

  // reply buffer
  logic [95:0] msg_q, msg_d;
  logic [3:0]  rem_q, rem_d;
  logic        user_q, user_d, oflag_q, oflag_d;
  logic [1:0]  outc_q, outc_d;
  logic        busy_q;

  // memory
  logic [31:0]   mem [Depth];
  logic [31:0]   rd_q;
  logic          mem_we, mem_re;
  logic [Aw-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd, clamped;

  logic        in_acc, out_acc, is_tick, at_end, emits, check_ok, cell_ok, rd_cell_ok, load;
  logic [7:0]  rx;
  logic [3:0]  len;
  logic [1:0]  lane;
  logic [16:0] addr_cur, addr_rd;

  assign busy_q   = (rem_q != 4'd0);
  assign is_tick  = s_axis_tuser_i;
  assign rx       = s_axis_tdata_i;
  assign len      = stcp_pkg::payload_len(id_q);
  assign at_end   = (pos_q == len - 4'd1);
  assign emits    = (phase_q == stcp_pkg::PH_PAYLOAD) &&
                    (is_tick ? (wait_q >= timeout_q) : at_end);
  assign s_axis_tready_o = !clearing_q && (!busy_q || !emits);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = m_axis_tvalid_o && m_axis_tready_i;
  assign load     = in_acc && emits;
  assign check_ok = ({rx, cklo_q} == exp_q);
  assign lane     = 2'(pos_q - 4'd3);

  assign cell_ok    = (row_q != 8'd0) && (9'(row_q) < 9'(TABLE_ROWS)) &&
                      (col_q != 8'd0) && (9'(col_q) < 9'(TABLE_COLS));
  assign rd_cell_ok = (row_q != 8'd0) && (9'(row_q) < 9'(TABLE_ROWS)) &&
                      (rx != 8'd0) && (9'(rx) < 9'(TABLE_COLS));
  assign addr_cur = 17'(row_q) * 17'(TABLE_COLS) + 17'(col_q);
  assign addr_rd  = 17'(row_q) * 17'(TABLE_COLS) + 17'(rx);

  stcp_clamp u_clamp (
    .value_i  (val_q),
    .min_i    (min_q),
    .max_i    (max_q),
    .result_o (clamped)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      case (phase_q)
        stcp_pkg::PH_IDLE: begin
          if (!is_tick && stcp_pkg::payload_len(rx) != 4'd0) phase_d = stcp_pkg::PH_PAYLOAD;
        end
        stcp_pkg::PH_PAYLOAD: begin
          if (emits) phase_d = stcp_pkg::PH_IDLE;
        end
        default: phase_d = stcp_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and reply load
  always_comb begin
    id_d   = id_q;
    pos_d  = pos_q;
    row_d  = row_q;
    col_d  = col_q;
    cklo_d = cklo_q;
    val_d  = val_q;
    exp_d  = exp_q;
    wait_d = wait_q;
    send_d = send_q;
    msg_d  = msg_q;
    rem_d  = rem_q;
    user_d = user_q;
    outc_d = outc_q;
    oflag_d = oflag_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = clr_q;
    mem_wd = 32'd0;
    mem_ra = addr_rd[Aw-1:0];

    if (out_acc) begin
      msg_d = {8'd0, msg_q[95:8]};
      rem_d = rem_q - 4'd1;
    end

    if (clearing_q) begin
      mem_we = 1'b1;
    end else if (in_acc) begin
      if (phase_q == stcp_pkg::PH_IDLE) begin
        if (!is_tick && stcp_pkg::payload_len(rx) != 4'd0) begin
          id_d   = rx;
          pos_d  = 4'd0;
          row_d  = 8'd0;
          col_d  = 8'd0;
          val_d  = 32'd0;
          cklo_d = 8'd0;
          wait_d = 16'd0;
          exp_d  = stcp_pkg::CheckInit - 16'(rx);
        end
      end else if (is_tick) begin
        if (emits) begin
          msg_d   = 96'd0;
          rem_d   = 4'd1;
          user_d  = 1'b0;
          outc_d  = stcp_pkg::OUT_TIMEOUT;
          oflag_d = send_q;
        end else begin
          wait_d = wait_q + 16'd1;
        end
      end else if (at_end) begin
        user_d  = 1'b1;
        outc_d  = stcp_pkg::OUT_ACK;
        oflag_d = send_q;
        if (!check_ok) begin
          msg_d  = 96'd0;
          rem_d  = 4'd1;
          user_d = 1'b0;
          outc_d = stcp_pkg::OUT_CHECK;
        end else if (id_q == stcp_pkg::CMD_PING || id_q == stcp_pkg::CMD_SET ||
                     id_q == stcp_pkg::CMD_CLEAR) begin
          if (id_q == stcp_pkg::CMD_SET) send_d = 1'b1;
          if (id_q == stcp_pkg::CMD_CLEAR) send_d = 1'b0;
          oflag_d = (id_q == stcp_pkg::CMD_SET) ? 1'b1 :
                    (id_q == stcp_pkg::CMD_CLEAR) ? 1'b0 : send_q;
          msg_d = {56'd0, stcp_pkg::AckEnd, id_q};
          rem_d = 4'd5;
        end else if (!cell_ok) begin
          msg_d  = 96'd0;
          rem_d  = 4'd1;
          user_d = 1'b0;
          outc_d = stcp_pkg::OUT_CELL;
        end else if (id_q == stcp_pkg::CMD_WRITE) begin
          mem_we = 1'b1;
          mem_wa = addr_cur[Aw-1:0];
          mem_wd = clamped;
          msg_d  = {32'd0, stcp_pkg::AckEnd, 8'd0, col_q, row_q, id_q};
          rem_d  = 4'd8;
        end else begin
          msg_d = {stcp_pkg::AckEnd, rd_q, 8'd0, col_q, row_q, id_q};
          rem_d = 4'd12;
        end
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q == len - 4'd2) begin
          cklo_d = rx;
        end else if (pos_q == 4'd0) begin
          row_d = rx;
          exp_d = exp_q - (16'(rx) << 1);
        end else if (pos_q == 4'd1) begin
          col_d = rx;
          exp_d = exp_q - (16'(rx) << 2);
          // fetch the cell now so it is ready when the checksum completes
          if (id_q == stcp_pkg::CMD_READ && rd_cell_ok) mem_re = 1'b1;
        end else if (pos_q >= 4'd3 && pos_q <= 4'd6) begin
          val_d[8*lane +: 8] = rx;
          exp_d = exp_q - (16'(rx) << pos_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= stcp_pkg::TimeoutRst;
      min_q      <= stcp_pkg::RatioMinRst;
      max_q      <= stcp_pkg::RatioMaxRst;
      phase_q    <= stcp_pkg::PH_IDLE;
      id_q       <= 8'd0;
      pos_q      <= 4'd0;
      row_q      <= 8'd0;
      col_q      <= 8'd0;
      cklo_q     <= 8'd0;
      val_q      <= 32'd0;
      exp_q      <= 16'd0;
      wait_q     <= 16'd0;
      send_q     <= 1'b0;
      clearing_q <= 1'b1;
      clr_q      <= '0;
      rem_q      <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          stcp_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i[15:0];
          stcp_pkg::CFG_MIN:     min_q     <= cfg_wdata_i;
          stcp_pkg::CFG_MAX:     max_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (32'(clr_q) == Depth - 1) clearing_q <= 1'b0;
      end
      phase_q <= phase_d;
      id_q    <= id_d;
      pos_q   <= pos_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cklo_q  <= cklo_d;
      val_q   <= val_d;
      exp_q   <= exp_d;
      wait_q  <= wait_d;
      send_q  <= send_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q   <= msg_d;
    user_q  <= user_d;
    outc_q  <= outc_d;
    oflag_q <= oflag_d;
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {5'd0, oflag_q, outc_q, msg_q[7:0]};
  assign m_axis_tuser_o  = user_q;
  assign m_axis_tlast_o  = (rem_q == 4'd1);

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) load |-> !busy_q)
    else $error("reply loaded while buffer busy");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) load |=> busy_q)
    else $error("reply load did not start output");
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready_o)
    else $error("input accepted during clearing pass");
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("error report longer than one result");
`endif

endmodule
